/* hdl/message_slot_mailbox_defines.svh */
// assertion macros for the message slot mailbox
// used by msm_ctrl and msm_datapath; no other dependencies
`ifndef MESSAGE_SLOT_MAILBOX_DEFINES_SVH
`define MESSAGE_SLOT_MAILBOX_DEFINES_SVH

// condition implies consequence in the same cycle
`define MSM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define MSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/msm_pkg.sv */
// shared types, codes and helpers for the message slot mailbox
// no dependencies
`default_nettype none

package msm_pkg;

   localparam int unsigned SLOTS_DEFAULT     = 16;
   localparam int unsigned MSG_BYTES_DEFAULT = 8;
   localparam int unsigned ID_W              = 16;
   localparam int unsigned MSG_W             = 64;
   localparam int unsigned STATUS_W          = 2;

   typedef enum logic {
      OP_SEND    = 1'b0,
      OP_RECEIVE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic commit;
      logic load;
   } ctrl_cmd_type;

   // keep bytes up to the first zero byte within nbytes, clear the rest
   function automatic logic [MSG_W-1:0] trim_message(input logic [MSG_W-1:0] msg,
                                                     input int unsigned nbytes);
      logic [MSG_W-1:0] kept;
      logic             alive;
      logic [7:0]       b;
      kept  = '0;
      alive = 1'b1;
      for (int unsigned i = 0; i < MSG_W / 8; i++) begin
         b = msg[8*i +: 8];
         if (i >= nbytes || b == 8'd0) begin
            alive = 1'b0;
         end
         if (alive) begin
            kept[8*i +: 8] = b;
         end
      end
      return kept;
   endfunction

endpackage

`default_nettype wire

/* hdl/msm_ctrl.sv */
// controller state machine for the message slot mailbox
// depends on msm_pkg and message_slot_mailbox_defines.svh
`default_nettype none

`include "message_slot_mailbox_defines.svh"

module msm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output msm_pkg::ctrl_cmd_type      cmd
);
   import msm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   logic      accept;

   // output register can take a new result
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_FINISH) && out_free);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // datapath commands
   always_comb begin
      cmd.capture = accept;
      cmd.commit  = (state_ff == ST_SEARCH);
      cmd.load    = (state_ff == ST_FINISH) && out_free;
   end

   // next state and response valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = accept ? ST_SEARCH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `MSM_ASSERT_NEXT(a_accept_to_search, clock, reset, accept, state_ff == ST_SEARCH,
      "accepted request did not start a search")
   `MSM_ASSERT_NEXT(a_search_to_finish, clock, reset, state_ff == ST_SEARCH,
      state_ff == ST_FINISH && !req_ready || state_ff == ST_FINISH && out_free,
      "search did not move to finish")
   `MSM_ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.load, rsp_valid_ff,
      "result load did not raise response valid")

endmodule

`default_nettype wire

/* hdl/msm_datapath.sv */
// slot table, payload memory and result registers for the message slot mailbox
// depends on msm_pkg and message_slot_mailbox_defines.svh
`default_nettype none

`include "message_slot_mailbox_defines.svh"

module msm_datapath #(
   parameter int unsigned SLOTS     = msm_pkg::SLOTS_DEFAULT,
   parameter int unsigned MSG_BYTES = msm_pkg::MSG_BYTES_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire msm_pkg::ctrl_cmd_type        cmd,
   input  wire logic                         req_operation,
   input  wire logic [msm_pkg::ID_W-1:0]     req_sender_id,
   input  wire logic [msm_pkg::ID_W-1:0]     req_receiver_id,
   input  wire logic [msm_pkg::MSG_W-1:0]    req_message,
   output logic [msm_pkg::STATUS_W-1:0]      rsp_status,
   output logic [msm_pkg::MSG_W-1:0]         rsp_message_res
);
   import msm_pkg::*;

   localparam int unsigned IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned PAYLOAD_W = 8 * MSG_BYTES;
   localparam int unsigned ENTRY_W   = ID_W + PAYLOAD_W;

   // captured request
   op_type                op_ff;
   logic [ID_W-1:0]       snd_ff;
   logic [ID_W-1:0]       rcv_ff;
   logic [PAYLOAD_W-1:0]  msg_ff;
   logic [MSG_W-1:0]      trimmed;

   // slot table
   logic [SLOTS-1:0]      valid_ff;
   logic [ID_W-1:0]       rcv_id_ff [SLOTS];
   logic [ENTRY_W-1:0]    mem [SLOTS];
   logic [ENTRY_W-1:0]    rd_data_ff;

   // search results
   logic [SLOTS-1:0]      free_vec;
   logic [SLOTS-1:0]      match_vec;
   logic [IDX_W-1:0]      free_idx;
   logic [IDX_W-1:0]      match_idx;
   logic                  free_any;
   logic                  match_any;
   logic                  do_write;
   logic                  do_take;

   // pending result
   status_type            status_ff;
   logic                  hit_ff;

   // output register
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [MSG_W-1:0]      rsp_msg_ff;
   logic [MSG_W-1:0]      rsp_msg_in;

   assign trimmed = trim_message(req_message, MSG_BYTES);

   // capture request fields
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= op_type'(req_operation);
         snd_ff <= req_sender_id;
         rcv_ff <= req_receiver_id;
         msg_ff <= trimmed[PAYLOAD_W-1:0];
      end
   end

   // free and match vectors with lowest-index priority encoders
   always_comb begin
      free_idx  = '0;
      match_idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         free_vec[i]  = !valid_ff[i];
         match_vec[i] = valid_ff[i] && (rcv_id_ff[i] == rcv_ff);
      end
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            free_idx = IDX_W'(i);
         end
         if (match_vec[i]) begin
            match_idx = IDX_W'(i);
         end
      end
      free_any  = |free_vec;
      match_any = |match_vec;
   end

   assign do_write = cmd.commit && (op_ff == OP_SEND) && free_any;
   assign do_take  = cmd.commit && (op_ff == OP_RECEIVE) && match_any;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (do_write) begin
         valid_ff[free_idx] <= 1'b1;
      end else if (do_take) begin
         valid_ff[match_idx] <= 1'b0;
      end
   end

   // receiver ids, compared in parallel
   always_ff @(posedge clock) begin
      if (do_write) begin
         rcv_id_ff[free_idx] <= rcv_ff;
      end
   end

   // sender and payload memory, one port
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[free_idx] <= {snd_ff, msg_ff};
      end else if (do_take) begin
         rd_data_ff <= mem[match_idx];
      end
   end

   // pending status
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (op_ff == OP_SEND) begin
            status_ff <= free_any ? STATUS_OK : STATUS_FULL;
            hit_ff    <= 1'b0;
         end else begin
            status_ff <= match_any ? STATUS_OK : STATUS_EMPTY;
            hit_ff    <= match_any;
         end
      end
   end

   // received payload widened to the port
   always_comb begin
      rsp_msg_in = '0;
      if (hit_ff) begin
         rsp_msg_in[PAYLOAD_W-1:0] = rd_data_ff[PAYLOAD_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_status_ff <= status_ff;
         rsp_msg_ff    <= rsp_msg_in;
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_message_res = rsp_msg_ff;

   `MSM_ASSERT_NEXT(a_send_sets_valid, clock, reset, do_write,
      valid_ff[$past(free_idx)], "send did not occupy the chosen slot")
   `MSM_ASSERT_NEXT(a_take_clears_valid, clock, reset, do_take,
      !valid_ff[$past(match_idx)], "receive did not free the matched slot")
   `MSM_ASSERT_SAME(a_write_take_excl, clock, reset, do_write || do_take,
      cmd.commit && !(do_write && do_take), "table update outside commit")

endmodule

`default_nettype wire

/* hdl/message_slot_mailbox.sv */
// Message slot mailbox: a table of SLOTS message slots. A send request stores
// the message (bytes up to the first zero byte, rest cleared), sender id and
// receiver id in the lowest free slot, or returns status full. A receive request
// takes the lowest occupied slot addressed to the given receiver id, returns its
// message and frees the slot, or returns status empty. Every request gives exactly
// one response. A request is accepted, then goes through the table search and
// update, then has its result moved to the output register; that last step
// overlaps acceptance of the next request, so with the response taken promptly
// the block takes a new request before it is through with the last one.
// The search is a parallel compare against the stored receiver ids followed by
// a priority encoder, and the payload sits in a single-port memory whose
// registered read sets the search-to-result step. Slot valid bits clear at reset.
// depends on msm_pkg, msm_ctrl, msm_datapath
`default_nettype none

module message_slot_mailbox #(
   parameter int unsigned SLOTS     = msm_pkg::SLOTS_DEFAULT,
   parameter int unsigned MSG_BYTES = msm_pkg::MSG_BYTES_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_operation,
   input  wire logic [msm_pkg::ID_W-1:0]   req_sender_id,
   input  wire logic [msm_pkg::ID_W-1:0]   req_receiver_id,
   input  wire logic [msm_pkg::MSG_W-1:0]  req_message,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [msm_pkg::STATUS_W-1:0]    rsp_status,
   output logic [msm_pkg::MSG_W-1:0]       rsp_message_res
);
   import msm_pkg::*;

   ctrl_cmd_type cmd;

   // request sequencing
   msm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // slot table and result path
   msm_datapath #(
      .SLOTS     (SLOTS),
      .MSG_BYTES (MSG_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_sender_id   (req_sender_id),
      .req_receiver_id (req_receiver_id),
      .req_message     (req_message),
      .rsp_status      (rsp_status),
      .rsp_message_res (rsp_message_res)
   );

endmodule

`default_nettype wire

/* tb/tb_message_slot_mailbox.sv */
`timescale 1ns / 1ps
// self-checking testbench for message_slot_mailbox: queued send and receive requests,
// a slot table tracked alongside the block, and field-by-field response checks
// depends on msm_pkg and the message_slot_mailbox rtl

module tb_message_slot_mailbox;
   import msm_pkg::*;

   localparam int TABLE_SLOTS     = SLOTS_DEFAULT;
   localparam int STORE_BYTES     = MSG_BYTES_DEFAULT;
   localparam int RANDOM_ITEMS    = 1300;
   localparam int STALL_LIMIT     = 1000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int HOLD_OFF_AFTER  = 200;
   localparam int DRAIN_CYCLES    = 20;

   typedef struct {
      op_type           op;
      logic [ID_W-1:0]  sender;
      logic [ID_W-1:0]  receiver;
      logic [MSG_W-1:0] body;
   } mail_request_type;

   typedef struct {
      status_type       status;
      logic [MSG_W-1:0] body;
   } mail_reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_operation = 1'b0;
   logic [ID_W-1:0]     req_sender_id = '0;
   logic [ID_W-1:0]     req_receiver_id = '0;
   logic [MSG_W-1:0]    req_message = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [MSG_W-1:0]    rsp_message_res;

   // requests waiting to be offered, replies the table predicts
   mail_request_type pending_requests[$];
   mail_reply_type   expected_replies[$];

   // slot table as the block should hold it
   logic             box_used [TABLE_SLOTS] = '{default: 1'b0};
   logic [ID_W-1:0]  box_to   [TABLE_SLOTS];
   logic [MSG_W-1:0] box_body [TABLE_SLOTS];

   logic [ID_W-1:0] id_pool [6];

   logic req_taken = 1'b0;
   int   burst_left = 1;
   int   gap_left = 0;
   int   hold_left = 0;
   bit   hold_done = 1'b0;
   int   ready_mode = 0;
   int   mode_left = 0;
   int   idle_cycles = 0;
   int   replies_seen = 0;
   int   mismatches = 0;
   int   sends_ok = 0;
   int   sends_full = 0;
   int   receives_ok = 0;
   int   receives_empty = 0;

   message_slot_mailbox dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_sender_id   (req_sender_id),
      .req_receiver_id (req_receiver_id),
      .req_message     (req_message),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_message_res (rsp_message_res)
   );

   always #2 clock = ~clock;

   // bytes up to the first zero byte survive, the rest read as zero
   function automatic logic [MSG_W-1:0] keep_to_first_null(logic [MSG_W-1:0] raw);
      logic [MSG_W-1:0] kept;
      kept = '0;
      for (int i = 0; i < STORE_BYTES; i++) begin
         if (raw[8*i +: 8] == 8'h00) break;
         kept[8*i +: 8] = raw[8*i +: 8];
      end
      return kept;
   endfunction

   // apply one request to the slot table and return the reply it earns
   function automatic mail_reply_type deliver(mail_request_type rq);
      mail_reply_type reply;
      int             hit;
      reply.status = STATUS_OK;
      reply.body   = '0;
      hit          = -1;
      if (rq.op == OP_SEND) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (hit < 0 && !box_used[i]) hit = i;
         end
         if (hit < 0) begin
            reply.status = STATUS_FULL;
            sends_full++;
         end else begin
            box_used[hit] = 1'b1;
            box_to[hit]   = rq.receiver;
            box_body[hit] = keep_to_first_null(rq.body);
            sends_ok++;
         end
      end else begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (hit < 0 && box_used[i] && box_to[i] == rq.receiver) hit = i;
         end
         if (hit < 0) begin
            reply.status = STATUS_EMPTY;
            receives_empty++;
         end else begin
            reply.body    = box_body[hit];
            box_used[hit] = 1'b0;
            receives_ok++;
         end
      end
      return reply;
   endfunction

   function automatic void queue_item(op_type op, logic [ID_W-1:0] sender,
                                      logic [ID_W-1:0] receiver, logic [MSG_W-1:0] body);
      mail_request_type rq;
      rq.op       = op;
      rq.sender   = sender;
      rq.receiver = receiver;
      rq.body     = body;
      pending_requests.push_back(rq);
   endfunction

   // mostly ids from a small pool so receives find mail, some fully random
   function automatic logic [ID_W-1:0] pick_receiver();
      if ($urandom_range(0, 6) == 0) return ID_W'($urandom);
      return id_pool[$urandom_range(0, 5)];
   endfunction

   // message bytes with scattered zero bytes, sometimes fully random
   function automatic logic [MSG_W-1:0] random_body();
      logic [MSG_W-1:0] body;
      if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
      for (int i = 0; i < STORE_BYTES; i++) begin
         body[8*i +: 8] = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      end
      return body;
   endfunction

   // one line per mismatch, and a running count
   task automatic flag_mismatch(string what);
      $display("mismatch at response %0d: %s", replies_seen, what);
      mismatches++;
   endtask

   // request driver: bursts of requests separated by random gaps
   always @(negedge clock) begin
      mail_request_type head;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            head = pending_requests.pop_front();
            req_operation   <= head.op;
            req_sender_id   <= head.sender;
            req_receiver_id <= head.receiver;
            req_message     <= head.body;
            req_valid       <= 1'b1;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 30);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side: stall mode re-picked at random, plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && replies_seen >= HOLD_OFF_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = 40;
         end
         mode_left--;
         case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // monitor: check responses, predict on each accepted request, watchdog
   always @(posedge clock) begin
      mail_reply_type   want;
      mail_request_type seen;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            replies_seen++;
            if (expected_replies.size() == 0) begin
               flag_mismatch($sformatf("response with none pending, status %0d", rsp_status));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch($sformatf("status %0d, wanted %s", rsp_status,
                                          want.status.name()));
               if (rsp_message_res !== want.body)
                  flag_mismatch($sformatf("message %h, wanted %h", rsp_message_res, want.body));
            end
         end
         if (req_valid && req_ready) begin
            seen.op       = op_type'(req_operation);
            seen.sender   = req_sender_id;
            seen.receiver = req_receiver_id;
            seen.body     = req_message;
            expected_replies.push_back(deliver(seen));
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int made;
      int phase_len;
      int send_pct;

      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      for (int i = 2; i < 6; i++) id_pool[i] = 16'($urandom_range(1, 16'hFFFE));

      // receive with id zero on an empty table
      queue_item(OP_RECEIVE, 16'h0000, 16'h0000, 64'h0);
      // extreme ids and message shapes
      queue_item(OP_SEND, 16'h0000, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_item(OP_SEND, 16'hFFFF, 16'hFFFF, 64'h0);
      queue_item(OP_SEND, 16'h0001, 16'h1234, 64'h1122_3344_5566_7700);
      queue_item(OP_SEND, 16'h8000, 16'h1234, 64'h8877_6655_0033_2211);
      queue_item(OP_SEND, 16'h7FFF, 16'h0000, 64'h00FE_DCBA_9876_5432);
      // fill the rest of the table, then one send too many
      for (int i = 0; i < TABLE_SLOTS - 5; i++)
         queue_item(OP_SEND, 16'($urandom), 16'h1234, random_body());
      queue_item(OP_SEND, 16'h5555, 16'h0042, 64'h0102_0304_0506_0708);
      queue_item(OP_RECEIVE, 16'h0000, 16'h0000, 64'h0);
      queue_item(OP_RECEIVE, 16'h0000, 16'hFFFF, 64'h0);
      queue_item(OP_RECEIVE, 16'h0000, 16'h1234, 64'h0);
      queue_item(OP_RECEIVE, 16'h0000, 16'h0BAD, 64'h0);
      // refill of the lowest freed slot, then lowest-slot priority on receive
      queue_item(OP_SEND, 16'h0002, 16'h0000, 64'h0000_0000_0000_00A5);
      queue_item(OP_RECEIVE, 16'h0000, 16'h0000, 64'h0);
      queue_item(OP_RECEIVE, 16'h0000, 16'h0000, 64'h0);

      // random phases that lean toward filling, draining or balance
      made = 0;
      while (made < RANDOM_ITEMS) begin
         phase_len = $urandom_range(8, 48);
         case ($urandom_range(0, 2))
            0: send_pct = 85;
            1: send_pct = 20;
            default: send_pct = 50;
         endcase
         for (int k = 0; k < phase_len; k++) begin
            if ($urandom_range(1, 100) <= send_pct)
               queue_item(OP_SEND, 16'($urandom), pick_receiver(), random_body());
            else
               queue_item(OP_RECEIVE, 16'($urandom), pick_receiver(), random_body());
            made++;
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid || expected_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sends: %0d stored, %0d refused as full; receives: %0d delivered, %0d found none",
               sends_ok, sends_full, receives_ok, receives_empty);
      $display("%0d responses checked, %0d mismatches", replies_seen, mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/msm_pkg.sv
hdl/msm_ctrl.sv
hdl/msm_datapath.sv
hdl/message_slot_mailbox.sv
tb/tb_message_slot_mailbox.sv
